// ===== design/client_session_rate_lockout_table_assert.svh =====
// assertion macros for the client session table
// used by the top level; no other dependencies
`ifndef CLIENT_SESSION_RATE_LOCKOUT_TABLE_ASSERT_SVH
`define CLIENT_SESSION_RATE_LOCKOUT_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
// check a property on every rising edge outside reset
`define CSRLT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("csrlt assertion failed");
// check that a condition leads to another in the next cycle
`define CSRLT_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("csrlt assertion failed");
`else
`define CSRLT_ASSERT(lbl, clk, rstn, prop)
`define CSRLT_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== design/csrlt_pkg.sv =====
// shared types and constants of the client session table
// no dependencies
`default_nettype none

package csrlt_pkg;

    localparam int FUNC_W       = 4;
    localparam int ID_W         = 32;
    localparam int TIME_W       = 32;
    localparam int CNT8_W       = 8;
    localparam int SLOT_OUT_W   = 3;
    localparam int ACTIVE_OUT_W = 4;
    localparam int RESULT_CAP   = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CNT8_W-1:0] COUNT_MAX = 8'hFF;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_CONNECT    = 4'd0;
    localparam logic [FUNC_W-1:0] FN_DISCONNECT = 4'd1;
    localparam logic [FUNC_W-1:0] FN_FRAME      = 4'd2;
    localparam logic [FUNC_W-1:0] FN_ACTIVITY   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_FAIL       = 4'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd5;
    localparam logic [FUNC_W-1:0] FN_SETAUTH    = 4'd6;
    localparam logic [FUNC_W-1:0] FN_QAUTH      = 4'd7;
    localparam logic [FUNC_W-1:0] FN_QLOCK      = 4'd8;
    localparam logic [FUNC_W-1:0] FN_SCAN       = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;

    // configuration reset values
    localparam logic [15:0] RST_RATE_WINDOW = 16'd1000;
    localparam logic [7:0]  RST_RATE_LIMIT  = 8'd5;
    localparam logic [7:0]  RST_MAX_FAILS   = 8'd5;
    localparam logic [31:0] RST_LOCKOUT     = 32'd300000;
    localparam logic [31:0] RST_TIMEOUT     = 32'd1800000;

    typedef struct packed {
        logic [15:0] rate_window_ms;
        logic [7:0]  rate_limit;
        logic [7:0]  max_failed_logins;
        logic [31:0] lockout_ms;
        logic [31:0] session_timeout_ms;
    } cfg_t;

    // one session slot as stored in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]   client;
        logic [TIME_W-1:0] last_activity;
        logic [TIME_W-1:0] last_fail;
        logic [TIME_W-1:0] window_start;
        logic [CNT8_W-1:0] fail_count;
        logic [CNT8_W-1:0] rate_count;
        logic              authed;
    } slot_rec_t;

endpackage

`default_nettype wire

// ===== design/client_session_rate_lockout_table.sv =====
// top level of the client session table: sequencer, slot flags and result register
// depends on csrlt_pkg, csrlt_cfg_regs, csrlt_slot_ram, csrlt_slot_update and the
// assertion header
//
// usage
// - request channel: in_valid / in_stall with func, client_id, now_ms, auth_value
// - result channel: out_valid / out_stall with found, answer, slot_index,
//   subject_id, active_clients, last; last marks the final result of a request
// - configuration: cfg_write with cfg_index and cfg_data, write only while idle
// - one request at a time; in_stall is high from acceptance until its final
//   result has been loaded into the result register
// - slot records live in a one-port-read memory walked one slot per cycle,
//   except while a scan hit waits behind a stalled result
// - connect writes the lowest free slot; per-client requests walk until the
//   matching slot, then update it in the exec state
// - a stalled result register holds its result; a result that would replace
//   it waits until the register frees up, and a new request is taken while a
//   final result still waits
// - reset clears the slot flags, the active count and both channels; the
//   configuration returns to its defaults; slot records need no clearing
`default_nettype none
`include "client_session_rate_lockout_table_assert.svh"

module client_session_rate_lockout_table #(
    parameter int MAX_CLIENTS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write port
    input  wire logic                                cfg_write,
    input  wire logic [csrlt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [csrlt_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [csrlt_pkg::FUNC_W-1:0]         func,
    input  wire logic [csrlt_pkg::ID_W-1:0]           client_id,
    input  wire logic [csrlt_pkg::TIME_W-1:0]         now_ms,
    input  wire logic                                auth_value,
    // result channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     found,
    output logic                                     answer,
    output logic      [csrlt_pkg::SLOT_OUT_W-1:0]     slot_index,
    output logic      [csrlt_pkg::ID_W-1:0]           subject_id,
    output logic      [csrlt_pkg::ACTIVE_OUT_W-1:0]   active_clients,
    output logic                                     last
);
    import csrlt_pkg::*;

    localparam int SLOT_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);
    localparam int RC_W   = $clog2(RESULT_CAP + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_CLIENTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EXEC,
        ST_CONN,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // output field width adapters
    function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[SLOT_OUT_W-1:0];
    endfunction

    function automatic logic [ACTIVE_OUT_W-1:0] active_out(input logic [CNT_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[ACTIVE_OUT_W-1:0];
    endfunction

    cfg_t cfg;

    // control state
    state_t                  state_reg,      state_next;
    logic [SLOT_W-1:0]       chk_reg,        chk_next;
    logic [MAX_CLIENTS-1:0]  in_use_reg,     in_use_next;
    logic [CNT_W-1:0]        active_reg,     active_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [RC_W-1:0]         found_cnt_reg,  found_cnt_next;
    logic                    out_valid_reg,  out_valid_next;

    // captured request
    logic [FUNC_W-1:0]       func_reg,       func_next;
    logic [ID_W-1:0]         id_reg,         id_next;
    logic [TIME_W-1:0]       now_reg,        now_next;
    logic                    authv_reg,      authv_next;

    // pending scan hit, held until the next one shows whether it is the last
    logic [SLOT_W-1:0]       pend_slot_reg,  pend_slot_next;
    logic [ID_W-1:0]         pend_id_reg,    pend_id_next;

    // result register
    logic                    out_found_reg,  out_found_next;
    logic                    out_answer_reg, out_answer_next;
    logic [SLOT_OUT_W-1:0]   out_slot_reg,   out_slot_next;
    logic [ID_W-1:0]         out_subj_reg,   out_subj_next;
    logic [ACTIVE_OUT_W-1:0] out_active_reg, out_active_next;
    logic                    out_last_reg,   out_last_next;

    // memory interface
    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_waddr;
    slot_rec_t               mem_wdata;
    logic [SLOT_W-1:0]       mem_raddr;
    slot_rec_t               rd_rec;

    slot_rec_t               upd_rec;
    logic                    upd_answer;
    slot_rec_t               conn_rec;

    logic                    accept;
    logic                    out_free;
    logic                    hit;
    logic                    timed_out;
    logic [TIME_W-1:0]       idle_age;
    logic [RC_W-1:0]         cnt_inc;
    logic                    free_any;
    logic [SLOT_W-1:0]       free_idx;
    logic                    advance;

    csrlt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csrlt_slot_ram #(
        .DEPTH  (MAX_CLIENTS),
        .ADDR_W (SLOT_W),
        .WIDTH  ($bits(slot_rec_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_rec)
    );

    csrlt_slot_update u_upd (
        .func       (func_reg),
        .now_ms     (now_reg),
        .auth_value (authv_reg),
        .cfg        (cfg),
        .rec_in     (rd_rec),
        .rec_out    (upd_rec),
        .answer     (upd_answer)
    );

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // rd_rec always holds the record of slot chk_reg
    assign hit       = in_use_reg[chk_reg] && (rd_rec.client == id_reg);
    assign idle_age  = now_reg - rd_rec.last_activity;
    assign timed_out = in_use_reg[chk_reg] && (idle_age > cfg.session_timeout_ms);
    assign cnt_inc   = found_cnt_reg + RC_W'(1);

    // lowest free slot for connect
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MAX_CLIENTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // fresh record written by connect
    always_comb
    begin
        conn_rec               = '0;
        conn_rec.client        = id_reg;
        conn_rec.last_activity = now_reg;
    end

    // read address: slot 0 while idle, then step through the table
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            mem_raddr = '0;
        end
        else if (advance)
        begin
            mem_raddr = chk_reg + SLOT_W'(1);
        end
        else
        begin
            mem_raddr = chk_reg;
        end
    end

    // the slot under check follows the read address
    assign chk_next = mem_raddr;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        active_next     = active_reg;
        pend_valid_next = pend_valid_reg;
        found_cnt_next  = found_cnt_reg;
        func_next       = func_reg;
        id_next         = id_reg;
        now_next        = now_reg;
        authv_next      = authv_reg;
        pend_slot_next  = pend_slot_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_found_next  = out_found_reg;
        out_answer_next = out_answer_reg;
        out_slot_next   = out_slot_reg;
        out_subj_next   = out_subj_reg;
        out_active_next = out_active_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = chk_reg;
        mem_wdata       = upd_rec;
        advance         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next       = func;
                    id_next         = client_id;
                    now_next        = now_ms;
                    authv_next      = auth_value;
                    pend_valid_next = 1'b0;
                    found_cnt_next  = '0;
                    if (func == FN_CONNECT)
                    begin
                        state_next = ST_CONN;
                    end
                    else if (func == FN_SCAN)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (func <= FN_QLOCK)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        // unused operation codes answer with an empty result
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (hit)
                begin
                    state_next = ST_EXEC;
                end
                else if (chk_reg == LAST_SLOT)
                begin
                    state_next = ST_FLUSH;  // unknown client
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    mem_we = 1'b1;
                    if (func_reg == FN_DISCONNECT)
                    begin
                        in_use_next[chk_reg] = 1'b0;
                        if (active_reg != '0)
                        begin
                            active_next = active_reg - CNT_W'(1);
                        end
                    end
                    out_valid_next  = 1'b1;
                    out_found_next  = 1'b1;
                    out_answer_next = upd_answer;
                    out_slot_next   = slot_out(chk_reg);
                    out_subj_next   = rd_rec.client;
                    out_active_next = active_out(active_next);
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_CONN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_answer_next = 1'b0;
                    out_last_next   = 1'b1;
                    if (free_any)
                    begin
                        mem_we                = 1'b1;
                        mem_waddr             = free_idx;
                        mem_wdata             = conn_rec;
                        in_use_next[free_idx] = 1'b1;
                        active_next           = active_reg + CNT_W'(1);
                        out_found_next        = 1'b1;
                        out_slot_next         = slot_out(free_idx);
                        out_subj_next         = id_reg;
                    end
                    else
                    begin
                        out_found_next = 1'b0;
                        out_slot_next  = '0;
                        out_subj_next  = '0;
                    end
                    out_active_next = active_out(active_next);
                    state_next      = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (timed_out && pend_valid_reg && !out_free)
                begin
                    // previous hit cannot leave yet: hold on this slot
                    advance = 1'b0;
                end
                else
                begin
                    if (timed_out)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_found_next  = 1'b1;
                            out_answer_next = 1'b0;
                            out_slot_next   = slot_out(pend_slot_reg);
                            out_subj_next   = pend_id_reg;
                            out_active_next = active_out(active_reg);
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = chk_reg;
                        pend_id_next    = rd_rec.client;
                        found_cnt_next  = cnt_inc;
                    end
                    if ((chk_reg == LAST_SLOT) ||
                        (timed_out && (cnt_inc == RC_W'(RESULT_CAP))))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
            end

            ST_FLUSH:
            begin
                // final result: the pending scan hit, or an empty result
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = pend_valid_reg;
                    out_answer_next = 1'b0;
                    out_slot_next   = pend_valid_reg ? slot_out(pend_slot_reg) : '0;
                    out_subj_next   = pend_valid_reg ? pend_id_reg : '0;
                    out_active_next = active_out(active_reg);
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chk_reg        <= '0;
            in_use_reg     <= '0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            found_cnt_reg  <= '0;
            func_reg       <= '0;
            id_reg         <= '0;
            now_reg        <= '0;
            authv_reg      <= 1'b0;
            pend_slot_reg  <= '0;
            pend_id_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_answer_reg <= 1'b0;
            out_slot_reg   <= '0;
            out_subj_reg   <= '0;
            out_active_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chk_reg        <= chk_next;
            in_use_reg     <= in_use_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            found_cnt_reg  <= found_cnt_next;
            func_reg       <= func_next;
            id_reg         <= id_next;
            now_reg        <= now_next;
            authv_reg      <= authv_next;
            pend_slot_reg  <= pend_slot_next;
            pend_id_reg    <= pend_id_next;
            out_valid_reg  <= out_valid_next;
            out_found_reg  <= out_found_next;
            out_answer_reg <= out_answer_next;
            out_slot_reg   <= out_slot_next;
            out_subj_reg   <= out_subj_next;
            out_active_reg <= out_active_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign found          = out_found_reg;
    assign answer         = out_answer_reg;
    assign slot_index     = out_slot_reg;
    assign subject_id     = out_subj_reg;
    assign active_clients = out_active_reg;
    assign last           = out_last_reg;

    // active count tracks the slot flags
    `CSRLT_ASSERT(a_active_matches_flags, clk, rst_n, active_reg == CNT_W'($countones(in_use_reg)))
    // an empty result always closes its request
    `CSRLT_ASSERT(a_empty_is_last, clk, rst_n, (out_valid_reg && !out_found_reg) |-> out_last_reg)
    // no scan hit is left behind once the block is idle again
    `CSRLT_ASSERT(a_idle_no_pending, clk, rst_n, (state_reg == ST_IDLE) |-> !pend_valid_reg)
    // a slot write finishes the request in the following cycle
    `CSRLT_ASSERT_NEXT(a_write_ends_request, clk, rst_n, mem_we, state_reg == ST_IDLE)

endmodule

`default_nettype wire

// ===== design/csrlt_cfg_regs.sv =====
// configuration registers of the client session table
// depends on csrlt_pkg
`default_nettype none

module csrlt_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [csrlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csrlt_pkg::CFG_DATA_W-1:0] cfg_data,
    output csrlt_pkg::cfg_t                      cfg
);
    import csrlt_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_window_ms     <= RST_RATE_WINDOW;
            cfg_reg.rate_limit         <= RST_RATE_LIMIT;
            cfg_reg.max_failed_logins  <= RST_MAX_FAILS;
            cfg_reg.lockout_ms         <= RST_LOCKOUT;
            cfg_reg.session_timeout_ms <= RST_TIMEOUT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RATE_WINDOW: cfg_reg.rate_window_ms     <= cfg_data[15:0];
                CFG_RATE_LIMIT:  cfg_reg.rate_limit         <= cfg_data[7:0];
                CFG_MAX_FAILS:   cfg_reg.max_failed_logins  <= cfg_data[7:0];
                CFG_LOCKOUT:     cfg_reg.lockout_ms         <= cfg_data;
                CFG_TIMEOUT:     cfg_reg.session_timeout_ms <= cfg_data;
                default:         ;  // writes beyond the list are dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/csrlt_slot_ram.sv =====
// slot memory: one write port, one read port with registered read data
// no dependencies
`default_nettype none

module csrlt_slot_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int WIDTH  = 145
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/csrlt_slot_update.sv =====
// per-request update of one matched session slot and its answer bit
// depends on csrlt_pkg
`default_nettype none

module csrlt_slot_update (
    input  wire logic [csrlt_pkg::FUNC_W-1:0] func,
    input  wire logic [csrlt_pkg::TIME_W-1:0] now_ms,
    input  wire logic                         auth_value,
    input  wire csrlt_pkg::cfg_t              cfg,
    input  wire csrlt_pkg::slot_rec_t         rec_in,
    output csrlt_pkg::slot_rec_t              rec_out,
    output logic                              answer
);
    import csrlt_pkg::*;

    logic [TIME_W-1:0] win_age;
    logic [TIME_W-1:0] fail_age;
    logic [CNT8_W-1:0] rate_inc;

    assign win_age  = now_ms - rec_in.window_start;
    assign fail_age = now_ms - rec_in.last_fail;
    assign rate_inc = (rec_in.rate_count != COUNT_MAX) ? rec_in.rate_count + 8'd1
                                                        : rec_in.rate_count;

    always_comb
    begin
        rec_out = rec_in;
        answer  = 1'b0;
        unique case (func)
            FN_DISCONNECT:
            begin
                rec_out.authed     = 1'b0;
                rec_out.fail_count = '0;
            end
            FN_FRAME:
            begin
                if (win_age > {16'd0, cfg.rate_window_ms})
                begin
                    rec_out.window_start = now_ms;
                    rec_out.rate_count   = 8'd1;
                    answer               = 1'b1;
                end
                else
                begin
                    rec_out.rate_count = rate_inc;
                    answer             = (rate_inc <= cfg.rate_limit);
                end
            end
            FN_ACTIVITY:
            begin
                rec_out.last_activity = now_ms;
            end
            FN_FAIL:
            begin
                if (rec_in.fail_count != COUNT_MAX)
                begin
                    rec_out.fail_count = rec_in.fail_count + 8'd1;
                end
                rec_out.last_fail = now_ms;
            end
            FN_CLEAR:
            begin
                rec_out.fail_count = '0;
                rec_out.last_fail  = '0;
            end
            FN_SETAUTH:
            begin
                rec_out.authed     = auth_value;
                rec_out.fail_count = '0;
                rec_out.last_fail  = '0;
            end
            FN_QAUTH:
            begin
                answer = rec_in.authed;
            end
            FN_QLOCK:
            begin
                answer = (rec_in.fail_count >= cfg.max_failed_logins) &&
                         (fail_age < cfg.lockout_ms);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/sv/client_session_rate_lockout_table_test.sv =====
// self-checking testbench for the client session table: directed table, then random phases
// depends on csrlt_pkg and client_session_rate_lockout_table; predicts the results itself, bar typed rows
`default_nettype none

module client_session_rate_lockout_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csrlt_pkg::*;

    localparam int SLOTS          = 8;
    localparam int SETTLE_CYCLES  = SLOTS + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_REQUESTS = 46;
    localparam int BURST_LEN      = 6;
    localparam int ID_POOL_SIZE   = 10;

    // func codes the block does not use
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd10;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] t;
        logic              auth;
    } session_req_t;

    typedef struct packed {
        logic                    found;
        logic                    answer;
        logic [SLOT_OUT_W-1:0]   slot;
        logic [ID_W-1:0]         subject;
        logic [ACTIVE_OUT_W-1:0] active;
        logic                    last;
    } session_result_t;

    // one line of the directed table; typed rows carry their result by hand
    typedef struct {
        session_req_t    req;
        bit              typed;
        session_result_t want;
    } stim_row_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // block inputs, known from time zero
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic [FUNC_W-1:0]     func       = '0;
    logic [ID_W-1:0]       client_id  = '0;
    logic [TIME_W-1:0]     now_ms     = '0;
    logic                  auth_value = 1'b0;
    logic                  out_stall  = 1'b0;

    // block outputs
    logic                    in_stall;
    logic                    out_valid;
    logic                    found;
    logic                    answer;
    logic [SLOT_OUT_W-1:0]   slot_index;
    logic [ID_W-1:0]         subject_id;
    logic [ACTIVE_OUT_W-1:0] active_clients;
    logic                    last;

    client_session_rate_lockout_table #(
        .MAX_CLIENTS(SLOTS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .client_id     (client_id),
        .now_ms        (now_ms),
        .auth_value    (auth_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .answer        (answer),
        .slot_index    (slot_index),
        .subject_id    (subject_id),
        .active_clients(active_clients),
        .last          (last)
    );

    // session table as the testbench sees it
    logic                    sess_used      [SLOTS];
    logic [ID_W-1:0]         sess_client    [SLOTS];
    logic [TIME_W-1:0]       sess_seen      [SLOTS];
    logic [TIME_W-1:0]       sess_fail_time [SLOTS];
    logic [TIME_W-1:0]       sess_win_start [SLOTS];
    logic [CNT8_W-1:0]       sess_fails     [SLOTS];
    logic [CNT8_W-1:0]       sess_frames    [SLOTS];
    logic                    sess_authed    [SLOTS];
    logic [ACTIVE_OUT_W-1:0] live_count = '0;

    // settings mirror, starts at the reset values
    logic [15:0] win_len   = RST_RATE_WINDOW;
    logic [7:0]  frame_cap = RST_RATE_LIMIT;
    logic [7:0]  fail_cap  = RST_MAX_FAILS;
    logic [31:0] lock_len  = RST_LOCKOUT;
    logic [31:0] idle_len  = RST_TIMEOUT;

    // results of the request just accepted, and the ones still owed by the block
    session_result_t reply_buf [RESULT_CAP];
    int              reply_cnt;
    session_result_t replies_due [$];

    stim_row_t   dir_rows [$];
    logic [31:0] id_pool [ID_POOL_SIZE];
    logic [31:0] wall_ms;
    bit          idle_on = 1'b0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;

    function automatic session_result_t pack_result(input logic f, input logic a,
                                                    input logic [SLOT_OUT_W-1:0] s,
                                                    input logic [ID_W-1:0] subj,
                                                    input logic [ACTIVE_OUT_W-1:0] act,
                                                    input logic l);
        session_result_t res;
        res.found   = f;
        res.answer  = a;
        res.slot    = s;
        res.subject = subj;
        res.active  = act;
        res.last    = l;
        return res;
    endfunction

    // works out the results of one request and moves the table along with it
    function automatic void predict_session_reply(input session_req_t r);
        int   hit;
        logic ans;
        hit = -1;
        ans = 1'b0;
        reply_cnt = 0;

        // timeout scan: every stale slot in order, capped, last flag on the final one
        if (r.op == FN_SCAN)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (reply_cnt < RESULT_CAP && sess_used[i] && (r.t - sess_seen[i]) > idle_len)
                begin
                    reply_buf[reply_cnt] = pack_result(1'b1, 1'b0, 3'(i), sess_client[i],
                                                       live_count, 1'b0);
                    reply_cnt++;
                end
            end
            if (reply_cnt == 0)
            begin
                reply_buf[0] = pack_result(1'b0, 1'b0, '0, '0, live_count, 1'b1);
                reply_cnt = 1;
            end
            else
                reply_buf[reply_cnt-1].last = 1'b1;
            return;
        end

        // connect takes the lowest free slot, the per-client codes look up the id
        if (r.op == FN_CONNECT)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && !sess_used[i])
                    hit = i;
        end
        else if (r.op <= FN_QLOCK)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (hit < 0 && sess_used[i] && sess_client[i] == r.id)
                    hit = i;
        end

        reply_cnt = 1;
        if (hit < 0)
        begin
            // unknown client, full table or an unused code
            reply_buf[0] = pack_result(1'b0, 1'b0, '0, '0, live_count, 1'b1);
            return;
        end

        case (r.op)
            FN_CONNECT:
            begin
                sess_used[hit]      = 1'b1;
                sess_client[hit]    = r.id;
                sess_seen[hit]      = r.t;
                sess_fail_time[hit] = '0;
                sess_win_start[hit] = '0;
                sess_fails[hit]     = '0;
                sess_frames[hit]    = '0;
                sess_authed[hit]    = 1'b0;
                live_count++;
            end
            FN_DISCONNECT:
            begin
                sess_used[hit]   = 1'b0;
                sess_authed[hit] = 1'b0;
                sess_fails[hit]  = '0;
                if (live_count != 0)
                    live_count--;
            end
            FN_FRAME:
            begin
                if ((r.t - sess_win_start[hit]) > {16'd0, win_len})
                begin
                    sess_win_start[hit] = r.t;
                    sess_frames[hit]    = 8'd1;
                    ans = 1'b1;
                end
                else
                begin
                    if (sess_frames[hit] != COUNT_MAX)
                        sess_frames[hit]++;
                    ans = (sess_frames[hit] <= frame_cap);
                end
            end
            FN_ACTIVITY:
                sess_seen[hit] = r.t;
            FN_FAIL:
            begin
                if (sess_fails[hit] != COUNT_MAX)
                    sess_fails[hit]++;
                sess_fail_time[hit] = r.t;
            end
            FN_CLEAR:
            begin
                sess_fails[hit]     = '0;
                sess_fail_time[hit] = '0;
            end
            FN_SETAUTH:
            begin
                sess_authed[hit]    = r.auth;
                sess_fails[hit]     = '0;
                sess_fail_time[hit] = '0;
            end
            FN_QAUTH:
                ans = sess_authed[hit];
            default:
                ans = (sess_fails[hit] >= fail_cap) && ((r.t - sess_fail_time[hit]) < lock_len);
        endcase
        reply_buf[0] = pack_result(1'b1, ans, 3'(hit), sess_client[hit], live_count, 1'b1);
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void put_row(input logic [FUNC_W-1:0] op, input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] t, input logic auth,
                                    input bit typed, input session_result_t want);
        stim_row_t row;
        row.req   = '{op: op, id: id, t: t, auth: auth};
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // random request biased toward known clients and a slowly moving clock
    function automatic session_req_t random_request();
        session_req_t r;
        int           roll;
        roll = $urandom_range(0, 99);
        if (roll < 14)      r.op = FN_CONNECT;
        else if (roll < 23) r.op = FN_DISCONNECT;
        else if (roll < 48) r.op = FN_FRAME;
        else if (roll < 56) r.op = FN_ACTIVITY;
        else if (roll < 68) r.op = FN_FAIL;
        else if (roll < 72) r.op = FN_CLEAR;
        else if (roll < 78) r.op = FN_SETAUTH;
        else if (roll < 83) r.op = FN_QAUTH;
        else if (roll < 92) r.op = FN_QLOCK;
        else if (roll < 98) r.op = FN_SCAN;
        else                r.op = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));

        if ($urandom_range(0, 9) == 0)
            r.id = $urandom;
        else
            r.id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];

        // time steps: mostly inside a window, sometimes across a timeout, rarely anywhere
        roll = $urandom_range(0, 99);
        if (roll < 60)      wall_ms += 32'($urandom_range(0, 50));
        else if (roll < 90) wall_ms += 32'($urandom_range(0, 1500));
        else if (roll < 98) wall_ms += 32'($urandom_range(0, 4000000));
        else                wall_ms = $urandom;
        r.t    = wall_ms;
        r.auth = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // present one request, hold it until taken, then log what it should produce
    task automatic send_request(input session_req_t r, input bit typed,
                                input session_result_t want);
        int gap;
        gap = gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= r.op;
        client_id  <= r.id;
        now_ms     <= r.t;
        auth_value <= r.auth;
        do
            @(posedge clk);
        while (in_stall);
        predict_session_reply(r);
        if (typed)
            replies_due.push_back(want);
        else
            for (int k = 0; k < reply_cnt; k++)
                replies_due.push_back(reply_buf[k]);
    endtask

    // sender goes quiet until the block owes nothing
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_due.size() != 0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_RATE_WINDOW: win_len   = data[15:0];
            CFG_RATE_LIMIT:  frame_cap = data[7:0];
            CFG_MAX_FAILS:   fail_cap  = data[7:0];
            CFG_LOCKOUT:     lock_len  = data;
            default:         idle_len  = data;
        endcase
    endtask

    // new settings only once the block is idle; junk in the unused upper data bits
    task automatic load_settings(input logic [15:0] w, input logic [7:0] lim,
                                 input logic [7:0] fl, input logic [31:0] lk,
                                 input logic [31:0] tmo);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        put_reg(CFG_RATE_WINDOW, {16'($urandom), w});
        put_reg(CFG_RATE_LIMIT,  {24'($urandom), lim});
        put_reg(CFG_MAX_FAILS,   {24'($urandom), fl});
        put_reg(CFG_LOCKOUT,     lk);
        put_reg(CFG_TIMEOUT,     tmo);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase();
        for (int n = 0; n < PHASE_REQUESTS; n++)
        begin
            // idling comes and goes in stretches
            if (n % 18 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            // at mid phase let every result come home before going on
            if (n == PHASE_REQUESTS / 2)
                drain_results();
            send_request(random_request(), 1'b0, '0);
        end
    endtask

    // result side: random stall stretches while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 4) == 0)
                stall_left = gap_len();
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // every accepted result against the oldest one owed
    always @(posedge clk)
    begin
        session_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result with no request behind it: slot %0d id %0h",
                       slot_index, subject_id);
                mismatch_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("found", 32'(want.found), 32'(found));
                check_field("answer", 32'(want.answer), 32'(answer));
                check_field("slot_index", 32'(want.slot), 32'(slot_index));
                check_field("subject_id", want.subject, subject_id);
                check_field("active_clients", 32'(want.active), 32'(active_clients));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    // watchdog: too long with nothing moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("client_session_rate_lockout_table_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            sess_used[i]      = 1'b0;
            sess_client[i]    = '0;
            sess_seen[i]      = '0;
            sess_fail_time[i] = '0;
            sess_win_start[i] = '0;
            sess_fails[i]     = '0;
            sess_frames[i]    = '0;
            sess_authed[i]    = 1'b0;
        end

        // directed table, reset settings throughout
        // empty table: scan, unknown client and an unused code all come back empty
        put_row(FN_SCAN,      32'h0,        32'h0,        1'b0, 1'b1,
                pack_result(1'b0, 1'b0, 3'd0, 32'h0, 4'd0, 1'b1));
        put_row(FN_QAUTH,     32'h5,        32'h0,        1'b0, 1'b1,
                pack_result(1'b0, 1'b0, 3'd0, 32'h0, 4'd0, 1'b1));
        put_row(FN_UNUSED_HI, 32'h1234,     32'h0,        1'b1, 1'b1,
                pack_result(1'b0, 1'b0, 3'd0, 32'h0, 4'd0, 1'b1));
        // extreme ids take the first two slots
        put_row(FN_CONNECT,   32'h0,        32'h0,        1'b0, 1'b1,
                pack_result(1'b1, 1'b0, 3'd0, 32'h0, 4'd1, 1'b1));
        put_row(FN_CONNECT,   32'hFFFFFFFF, 32'd100,      1'b0, 1'b1,
                pack_result(1'b1, 1'b0, 3'd1, 32'hFFFFFFFF, 4'd2, 1'b1));
        // frame inside the first window, then one that opens a new window
        put_row(FN_FRAME,     32'hFFFFFFFF, 32'd100,      1'b0, 1'b0, '0);
        put_row(FN_FRAME,     32'hFFFFFFFF, 32'd1101,     1'b0, 1'b0, '0);
        put_row(FN_FAIL,      32'h0,        32'd1000,     1'b0, 1'b0, '0);
        put_row(FN_QLOCK,     32'h0,        32'd1500,     1'b0, 1'b0, '0);
        put_row(FN_CLEAR,     32'h0,        32'd1500,     1'b0, 1'b0, '0);
        put_row(FN_SETAUTH,   32'hFFFFFFFF, 32'd1500,     1'b1, 1'b0, '0);
        put_row(FN_QAUTH,     32'hFFFFFFFF, 32'd1600,     1'b0, 1'b0, '0);
        put_row(FN_ACTIVITY,  32'h0,        32'hFFFFFFFF, 1'b0, 1'b0, '0);
        // both sessions stale across the time wrap
        put_row(FN_SCAN,      32'h0,        32'h7FFFFFFF, 1'b0, 1'b0, '0);
        put_row(FN_DISCONNECT, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b1,
                pack_result(1'b1, 1'b0, 3'd1, 32'hFFFFFFFF, 4'd1, 1'b1));
        put_row(FN_DISCONNECT, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b1,
                pack_result(1'b0, 1'b0, 3'd0, 32'h0, 4'd1, 1'b1));
        // fill the table, then one connect too many
        for (int k = 1; k < SLOTS; k++)
            put_row(FN_CONNECT, 32'(k), 32'h1000, 1'b0, 1'b0, '0);
        put_row(FN_CONNECT,   32'(SLOTS),   32'h1000,     1'b0, 1'b1,
                pack_result(1'b0, 1'b0, 3'd0, 32'h0, 4'(SLOTS), 1'b1));
        // every slot stale: the scan reaches the full result count
        put_row(FN_SCAN,      32'h0,        32'h80000000, 1'b0, 1'b0, '0);

        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFFFFFF;
        id_pool[2] = 32'd1;
        id_pool[3] = 32'd2;
        id_pool[4] = 32'd3;
        id_pool[5] = 32'd5;
        for (int k = 6; k < ID_POOL_SIZE; k++)
            id_pool[k] = $urandom;
        wall_ms = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

        // widest settings; client 3 runs a short burst of frames and failures
        load_settings(16'hFFFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        idle_on = 1'b1;
        for (int k = 0; k < BURST_LEN; k++)
            send_request('{op: FN_FRAME, id: 32'd3, t: 32'h80000000, auth: 1'b0}, 1'b0, '0);
        for (int k = 0; k < BURST_LEN; k++)
            send_request('{op: FN_FAIL, id: 32'd3, t: 32'h80000000, auth: 1'b0}, 1'b0, '0);
        send_request('{op: FN_QLOCK, id: 32'd3, t: 32'h80000000, auth: 1'b0}, 1'b0, '0);
        random_phase();

        // narrowest settings: zero lockout, every session stale after any gap
        load_settings(16'd1, 8'd1, 8'd1, 32'd0, 32'd0);
        random_phase();

        load_settings(16'($urandom_range(1, 600)), 8'($urandom_range(1, 6)),
                      8'($urandom_range(1, 4)), 32'($urandom_range(100, 5000)),
                      32'($urandom_range(200, 6000)));
        random_phase();

        load_settings(16'($urandom_range(1, 3000)), 8'($urandom_range(1, 3)),
                      8'($urandom_range(1, 8)), 32'($urandom_range(0, 400000)),
                      32'($urandom_range(0, 2000000)));
        random_phase();

        // back to the reset values
        load_settings(RST_RATE_WINDOW, RST_RATE_LIMIT, RST_MAX_FAILS, RST_LOCKOUT,
                      RST_TIMEOUT);
        random_phase();

        // wait out every owed result, then a little longer for stray ones
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("client_session_rate_lockout_table_test: PASS");
        else
            $display("client_session_rate_lockout_table_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
